/* hw/rtl/sao_pkg.sv */
`default_nettype none

package sao_pkg;

    // Operation codes carried on the op port.
    localparam logic [1:0] OP_WR_OFF = 2'd0;
    localparam logic [1:0] OP_WR_EXT = 2'd1;
    localparam logic [1:0] OP_DECODE = 2'd2;

    // Offset table geometry. The extended index space is 14 bits wide.
    localparam int unsigned OFF_TABLE_DEPTH = 256;
    localparam int unsigned OFF_AW          = 8;
    localparam int unsigned EXT_IDX_W       = 14;
    localparam int unsigned EXT_SPAN        = 16384;

    // Sprite bytes held for the length of one decode transaction.
    typedef struct packed {
        logic [7:0]  x_low;
        logic [7:0]  attr;
        logic [15:0] code_word;
        logic [7:0]  y_low;
    } sprite_t;

    // Access controls for the two table memories. Each address serves both
    // the write port and the read port, which are never used together.
    typedef struct packed {
        logic                 off_we;
        logic                 off_re;
        logic [OFF_AW-1:0]    off_addr;
        logic                 ext_we;
        logic                 ext_re;
        logic [EXT_IDX_W-1:0] ext_addr;
    } sao_mem_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/sprite_attribute_offset_decoder.sv */
// Table write transactions leave busy low, so the next one may follow at once.
// A decode transaction passes the registered offset read, the registered extended read
// and the result register, with result_valid high for one cycle; busy is high in S_EXT and
// S_CALC for the chain of two dependent memory reads, so no new transaction is taken there.
// The receiver cannot stall. rst_n clears the sequencer, the strobe and small_screen_reg;
// table contents are undefined until written and get no clearing pass.
`default_nettype none

module sprite_attribute_offset_decoder
    import sao_pkg::*;
#(
    parameter int EXT_TABLE_DEPTH = 16384
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  op,
    input  wire logic [13:0] write_addr,
    input  wire logic [31:0] write_data,
    input  wire logic [7:0]  x_low,
    input  wire logic [7:0]  attr,
    input  wire logic [15:0] code_word,
    input  wire logic [7:0]  y_low,
    input  wire logic [7:0]  table_index,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data,
    output logic             result_valid,
    output logic [16:0]      tile_code,
    output logic [1:0]       color,
    output logic             flip_x,
    output logic             flip_y,
    output logic signed [9:0] pos_x,
    output logic signed [8:0] pos_y
);

    // Number of conditional subtractions that bring a 14-bit index below the depth.
    localparam int EXT_QBITS = $clog2((EXT_SPAN - 1) / EXT_TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXT  = 3'b010,
        S_CALC = 3'b100
    } state_t;

    state_t       state_reg;
    state_t       state_next;
    logic         small_screen_reg;
    sprite_t      sprite_reg;
    logic         accept;
    logic [EXT_IDX_W-1:0] ext_idx;
    sao_mem_ctl_t mem_ctl;
    logic [31:0]  off_word;
    logic [31:0]  ext_word;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            small_screen_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            small_screen_reg <= cfg_data;
        end
    end

    // Decode sequencer: offset read, extended read, then the result.
    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  state_next = (accept && op == OP_DECODE) ? S_EXT : S_IDLE;
            S_EXT:   state_next = S_CALC;
            S_CALC:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Hold the sprite bytes for the decode transaction.
    always_ff @(posedge clk)
    begin
        if (accept && op == OP_DECODE)
        begin
            sprite_reg.x_low     <= x_low;
            sprite_reg.attr      <= attr;
            sprite_reg.code_word <= code_word;
            sprite_reg.y_low     <= y_low;
        end
    end

    // Extended index from bytes 2 and 3, reduced modulo the table depth.
    always_comb
    begin
        ext_idx = {off_word[21:16], off_word[31:24]};
        for (int i = EXT_QBITS - 1; i >= 0; i--)
        begin
            if ({1'b0, ext_idx} >= 15'(EXT_TABLE_DEPTH << i))
            begin
                ext_idx = ext_idx - EXT_IDX_W'(EXT_TABLE_DEPTH << i);
            end
        end
    end

    // Memory controls. Writes beyond a table's depth are dropped.
    always_comb
    begin
        mem_ctl.off_we   = accept && (op == OP_WR_OFF) && (write_addr[13:OFF_AW] == '0);
        mem_ctl.off_re   = accept && (op == OP_DECODE);
        mem_ctl.off_addr = (op == OP_DECODE) ? table_index : write_addr[OFF_AW-1:0];
        mem_ctl.ext_we   = accept && (op == OP_WR_EXT)
                         && ({1'b0, write_addr} < 15'(EXT_TABLE_DEPTH));
        mem_ctl.ext_re   = (state_reg == S_EXT);
        mem_ctl.ext_addr = (state_reg == S_EXT) ? ext_idx : write_addr;
    end

    sao_tables #(
        .EXT_TABLE_DEPTH (EXT_TABLE_DEPTH)
    ) u_tables (
        .clk      (clk),
        .ctl      (mem_ctl),
        .wdata    (write_data),
        .off_word (off_word),
        .ext_word (ext_word)
    );

    sao_decode u_decode (
        .clk          (clk),
        .rst_n        (rst_n),
        .calc_en      (state_reg == S_CALC),
        .small_screen (small_screen_reg),
        .sprite       (sprite_reg),
        .off_word     (off_word),
        .ext_word     (ext_word),
        .result_valid (result_valid),
        .tile_code    (tile_code),
        .color        (color),
        .flip_x       (flip_x),
        .flip_y       (flip_y),
        .pos_x        (pos_x),
        .pos_y        (pos_y)
    );

endmodule

`default_nettype wire

/* hw/rtl/sao_tables.sv */
`default_nettype none

module sao_tables
    import sao_pkg::*;
#(
    parameter int EXT_TABLE_DEPTH = 16384
)
(
    input  wire logic         clk,
    input  wire sao_mem_ctl_t ctl,
    input  wire logic [31:0]  wdata,
    output logic [31:0]       off_word,
    output logic [31:0]       ext_word
);

    localparam int EXT_AW = $clog2(EXT_TABLE_DEPTH);

    logic [31:0] off_mem [OFF_TABLE_DEPTH];
    logic [31:0] ext_mem [EXT_TABLE_DEPTH];
    logic [31:0] off_rdata_reg;
    logic [31:0] ext_rdata_reg;

    // Offset table: one write or one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (ctl.off_we)
        begin
            off_mem[ctl.off_addr] <= wdata;
        end
        if (ctl.off_re)
        begin
            off_rdata_reg <= off_mem[ctl.off_addr];
        end
    end

    // Extended offset table: the address is already reduced below the depth.
    always_ff @(posedge clk)
    begin
        if (ctl.ext_we)
        begin
            ext_mem[ctl.ext_addr[EXT_AW-1:0]] <= wdata;
        end
        if (ctl.ext_re)
        begin
            ext_rdata_reg <= ext_mem[ctl.ext_addr[EXT_AW-1:0]];
        end
    end

    assign off_word = off_rdata_reg;
    assign ext_word = ext_rdata_reg;

endmodule

`default_nettype wire

/* hw/rtl/sao_decode.sv */
`default_nettype none

module sao_decode
    import sao_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        calc_en,
    input  wire logic        small_screen,
    input  wire sprite_t     sprite,
    input  wire logic [31:0] off_word,
    input  wire logic [31:0] ext_word,
    output logic             result_valid,
    output logic [16:0]      tile_code,
    output logic [1:0]       color,
    output logic             flip_x,
    output logic             flip_y,
    output logic signed [9:0] pos_x,
    output logic signed [8:0] pos_y
);

    logic        is_ext;
    logic [15:0] y_off;
    logic [8:0]  x_off;
    logic [4:0]  code_inc;
    logic [8:0]  x_wrap;
    logic signed [10:0] y_sum;
    logic        y_above_zero;

    logic        result_valid_reg;
    logic [16:0] tile_code_reg;
    logic [16:0] tile_code_next;
    logic [1:0]  color_reg;
    logic        flip_x_reg;
    logic        flip_x_next;
    logic        flip_y_reg;
    logic        flip_y_next;
    logic [9:0]  pos_x_reg;
    logic [9:0]  pos_x_next;
    logic [8:0]  pos_y_reg;
    logic [8:0]  pos_y_next;

    // Pick the offsets from the extended entry or straight from the word.
    always_comb
    begin
        is_ext   = off_word[23];
        y_off    = is_ext ? ext_word[15:0] : {7'd0, off_word[24], off_word[15:8]};
        x_off    = is_ext ? ext_word[24:16] : {off_word[16], off_word[7:0]};
        code_inc = is_ext ? y_off[13:9] : 5'd0;
    end

    // Code increment, flip toggles and the wrapped positions.
    always_comb
    begin
        tile_code_next = {1'b0, sprite.code_word} + {12'd0, code_inc};
        flip_x_next    = sprite.attr[5] ^ (is_ext & y_off[15]);
        flip_y_next    = sprite.attr[4] ^ (is_ext & y_off[14]);

        // Only the low nine bits of x survive, so a 9-bit sum is enough.
        x_wrap     = {sprite.attr[7], sprite.x_low} + x_off;
        pos_x_next = {x_wrap[8] & x_wrap[7], x_wrap};

        // The y offset is a signed 9-bit value.
        y_sum = $signed({2'b00, sprite.attr[6], sprite.y_low})
              + $signed({{2{y_off[8]}}, y_off[8:0]});
        y_above_zero = !y_sum[10] && (y_sum != 11'sd0);
        if (small_screen && y_above_zero)
        begin
            pos_y_next = {1'b0, y_sum[7:0]};
        end
        else
        begin
            pos_y_next = y_sum[8:0];
        end
    end

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= calc_en;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (calc_en)
        begin
            tile_code_reg <= tile_code_next;
            color_reg     <= sprite.attr[1:0];
            flip_x_reg    <= flip_x_next;
            flip_y_reg    <= flip_y_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign tile_code    = tile_code_reg;
    assign color        = color_reg;
    assign flip_x       = flip_x_reg;
    assign flip_y       = flip_y_reg;
    assign pos_x        = $signed(pos_x_reg);
    assign pos_y        = $signed(pos_y_reg);

endmodule

`default_nettype wire

/* test/sao_decode_monitor.sv */
`timescale 1ns / 100ps

module sao_decode_monitor
    import sao_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic [1:0]  op,
    input  wire logic [13:0] write_addr,
    input  wire logic [31:0] write_data,
    input  wire logic [7:0]  x_low,
    input  wire logic [7:0]  attr,
    input  wire logic [15:0] code_word,
    input  wire logic [7:0]  y_low,
    input  wire logic [7:0]  table_index,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic        cfg_data,
    input  wire logic        result_valid,
    input  wire logic [16:0] tile_code,
    input  wire logic [1:0]  color,
    input  wire logic        flip_x,
    input  wire logic        flip_y,
    input  wire logic [9:0]  pos_x,
    input  wire logic [8:0]  pos_y,
    input  wire logic        final_check,
    output int               errors,
    output int               pending
);

    // One screen descriptor as the block presents it.
    typedef struct packed {
        logic [16:0] tile_code;
        logic [1:0]  color;
        logic        flip_x;
        logic        flip_y;
        logic [9:0]  pos_x;
        logic [8:0]  pos_y;
    } sprite_desc_t;

    // Local copies of both offset tables and of the screen mode register.
    logic [31:0]  off_words [OFF_TABLE_DEPTH];
    logic [31:0]  ext_words [EXT_SPAN];
    logic         small_screen;
    sprite_desc_t expected_desc [$];

    // Work out the descriptor for one sprite from the current table contents.
    function automatic sprite_desc_t decode_sprite(input logic [7:0] xl, input logic [7:0] at,
                                                   input logic [15:0] cw, input logic [7:0] yl,
                                                   input logic [7:0] ti);
        sprite_desc_t d;
        logic [31:0]  word;
        logic [31:0]  ew;
        logic [15:0]  xo;
        logic [15:0]  yo;
        logic [13:0]  eidx;
        logic [8:0]   xu;
        logic         fx;
        logic         fy;
        int           x;
        int           y;
        int           xs;
        int           ys;
        int           code;
        code = int'(cw);
        fx   = at[5];
        fy   = at[4];
        x    = int'({at[7], xl});
        y    = int'({at[6], yl});
        word = off_words[ti];
        if (word[23])
        begin
            // Extended entry: y offset low half, x offset high half.
            eidx = {word[21:16], word[31:24]};
            ew   = ext_words[eidx];
            yo   = ew[15:0];
            xo   = ew[31:16];
            code = code + int'(yo[13:9]);
            fy   = fy ^ yo[14];
            fx   = fx ^ yo[15];
        end
        else
        begin
            yo = {7'd0, word[24], word[15:8]};
            xo = {7'd0, word[16], word[7:0]};
        end
        ys = int'(yo[7:0]) - (yo[8] ? 256 : 0);
        xs = int'(xo[8:0]);
        if (xs >= 384)
            xs = xs - 512;
        x = x + xs;
        y = y + ys;
        if (small_screen && y > 0)
            y = y & 255;
        xu          = x[8:0];
        d.pos_y     = y[8:0];
        d.pos_x     = (xu >= 9'd384) ? {1'b1, xu} : {1'b0, xu};
        d.tile_code = code[16:0];
        d.color     = at[1:0];
        d.flip_x    = fx;
        d.flip_y    = fy;
        return d;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endfunction

    // Compare results, then fold accepted transactions into the local state.
    always @(posedge clk or negedge rst_n)
    begin
        sprite_desc_t want;
        if (!rst_n)
        begin
            small_screen = 1'b0;
            expected_desc.delete();
            pending <= 0;
        end
        else
        begin
            if (result_valid)
            begin
                if (expected_desc.size() == 0)
                begin
                    $error("result arrived with no decode outstanding");
                    errors++;
                end
                else
                begin
                    want = expected_desc.pop_front();
                    check_field("tile_code", int'(want.tile_code), int'(tile_code));
                    check_field("color", int'(want.color), int'(color));
                    check_field("flip_x", int'(want.flip_x), int'(flip_x));
                    check_field("flip_y", int'(want.flip_y), int'(flip_y));
                    check_field("pos_x", int'($signed(want.pos_x)), int'($signed(pos_x)));
                    check_field("pos_y", int'($signed(want.pos_y)), int'($signed(pos_y)));
                end
            end

            if (start && !busy)
            begin
                case (op)
                    OP_WR_OFF:
                        if (write_addr < OFF_TABLE_DEPTH)
                            off_words[write_addr[7:0]] = write_data;
                    OP_WR_EXT:
                        ext_words[write_addr] = write_data;
                    OP_DECODE:
                        expected_desc.push_back(decode_sprite(x_low, attr, code_word,
                                                              y_low, table_index));
                    default:
                        ;
                endcase
            end

            if (cfg_valid && cfg_ready)
                small_screen = cfg_data;

            if (final_check && expected_desc.size() != 0)
            begin
                $error("%0d decode results never arrived", expected_desc.size());
                errors++;
            end

            pending <= expected_desc.size();
        end
    end

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps

module tb;
    import sao_pkg::*;

    localparam logic [1:0] OP_UNUSED      = 2'd3;
    localparam int         SETTLE_CYCLES  = 8;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         PHASE_ITEMS    = 216;
    localparam int         NUM_PHASES     = 6;

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        start        = 1'b0;
    logic [1:0]  op           = OP_WR_OFF;
    logic [13:0] write_addr   = '0;
    logic [31:0] write_data   = '0;
    logic [7:0]  x_low        = '0;
    logic [7:0]  attr         = '0;
    logic [15:0] code_word    = '0;
    logic [7:0]  y_low        = '0;
    logic [7:0]  table_index  = '0;
    logic        cfg_valid    = 1'b0;
    logic        cfg_data     = 1'b0;
    logic        final_check  = 1'b0;
    logic        busy;
    logic        cfg_ready;
    logic        result_valid;
    logic [16:0] tile_code;
    logic [1:0]  color;
    logic        flip_x;
    logic        flip_y;
    logic signed [9:0] pos_x;
    logic signed [8:0] pos_y;
    int          errors;
    int          pending;

    // Stimulus bookkeeping: which table entries hold defined data.
    logic [31:0] off_shadow [OFF_TABLE_DEPTH];
    bit          off_written [OFF_TABLE_DEPTH];
    bit          ext_written [EXT_SPAN];
    int          off_list [$];
    int          sender_idle_pct = 0;
    int          burst_left      = 0;
    int          decode_count    = 0;
    int          write_count     = 0;
    int          cfg_count       = 0;
    int          quiet_cycles    = 0;

    // Sender idle profile and screen mode of each random phase.
    int          idle_pct [NUM_PHASES]    = '{28, 28, 87, 87, 0, 0};
    bit          screen_mode [NUM_PHASES] = '{1, 0, 0, 1, 1, 0};

    sprite_attribute_offset_decoder #(
        .EXT_TABLE_DEPTH(16384)
    ) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(op),
        .write_addr(write_addr), .write_data(write_data), .x_low(x_low), .attr(attr),
        .code_word(code_word), .y_low(y_low), .table_index(table_index),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .result_valid(result_valid), .tile_code(tile_code), .color(color),
        .flip_x(flip_x), .flip_y(flip_y), .pos_x(pos_x), .pos_y(pos_y)
    );

    sao_decode_monitor monitor (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(op),
        .write_addr(write_addr), .write_data(write_data), .x_low(x_low), .attr(attr),
        .code_word(code_word), .y_low(y_low), .table_index(table_index),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .result_valid(result_valid), .tile_code(tile_code), .color(color),
        .flip_x(flip_x), .flip_y(flip_y), .pos_x(pos_x), .pos_y(pos_y),
        .final_check(final_check), .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog: end the run if no transaction of any kind moves for too long.
    always @(posedge clk)
    begin
        if ((start && !busy) || (cfg_valid && cfg_ready) || result_valid)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Present one transaction after a random gap and hold it until accepted.
    task automatic push_item(input logic [1:0] o, input logic [13:0] wa, input logic [31:0] wd,
                             input logic [7:0] xl, input logic [7:0] at, input logic [15:0] cw,
                             input logic [7:0] yl, input logic [7:0] ti);
        int gap = 0;
        while (burst_left == 0 && sender_idle_pct > 0 && gap < 100 &&
               $urandom_range(0, 99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
            gap++;
        end
        if (burst_left > 0)
            burst_left--;
        else if ($urandom_range(0, 39) == 0)
            burst_left = 20;
        op          <= o;
        write_addr  <= wa;
        write_data  <= wd;
        x_low       <= xl;
        attr        <= at;
        code_word   <= cw;
        y_low       <= yl;
        table_index <= ti;
        start       <= 1'b1;
        do @(posedge clk); while (busy);
    endtask

    task automatic write_ext(input logic [13:0] a, input logic [31:0] w);
        push_item(OP_WR_EXT, a, w, 8'($urandom), 8'($urandom), 16'($urandom), 8'($urandom),
                  8'($urandom));
        ext_written[a] = 1'b1;
        write_count++;
    endtask

    // An offset word that points into the extended table gets its target defined too.
    task automatic write_offset(input logic [13:0] a, input logic [31:0] w);
        logic [13:0] eidx;
        push_item(OP_WR_OFF, a, w, 8'($urandom), 8'($urandom), 16'($urandom), 8'($urandom),
                  8'($urandom));
        write_count++;
        if (a < OFF_TABLE_DEPTH)
        begin
            if (!off_written[a[7:0]])
            begin
                off_written[a[7:0]] = 1'b1;
                off_list.push_back(int'(a[7:0]));
            end
            off_shadow[a[7:0]] = w;
            eidx = {w[21:16], w[31:24]};
            if (w[23] && !ext_written[eidx])
                write_ext(eidx, $urandom);
        end
    endtask

    task automatic decode(input logic [7:0] xl, input logic [7:0] at, input logic [15:0] cw,
                          input logic [7:0] yl, input logic [7:0] ti);
        push_item(OP_DECODE, 14'($urandom), $urandom, xl, at, cw, yl, ti);
        decode_count++;
    endtask

    // Mostly decodes of defined entries, with table rewrites and some unused ops.
    task automatic random_item();
        int          r;
        int          ti;
        logic [13:0] a;
        logic [31:0] w;
        r  = $urandom_range(0, 99);
        ti = off_list[$urandom_range(0, off_list.size() - 1)];
        if (r < 60)
            decode(8'($urandom), 8'($urandom), 16'($urandom), 8'($urandom), 8'(ti));
        else if (r < 85)
        begin
            if ($urandom_range(0, 3) == 0)
                a = 14'($urandom);
            else
                a = 14'($urandom_range(0, 255));
            w     = $urandom;
            w[23] = 1'($urandom_range(0, 1));
            write_offset(a, w);
        end
        else if (r < 95)
        begin
            w = off_shadow[ti];
            if ($urandom_range(0, 1) == 0)
                a = 14'($urandom);
            else
                a = {w[21:16], w[31:24]};
            write_ext(a, $urandom);
        end
        else
            push_item(OP_UNUSED, 14'($urandom), $urandom, 8'($urandom), 8'($urandom),
                      16'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // Drain the block, then write the screen mode register.
    task automatic settle_and_config(input logic v);
        start <= 1'b0;
        do @(posedge clk); while (pending != 0 || busy);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_count++;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        settle_and_config(1'b0);
        sender_idle_pct = 28;

        // Directed tables: zero offsets, largest direct offsets, the x and y wrap
        // boundaries, and extended entries at both ends of the index space.
        write_ext(14'h0000, 32'hffff_ffff);
        write_ext(14'h3fff, 32'h0180_3e00);
        write_offset(14'd0, 32'h0000_0000);
        write_offset(14'd1, 32'h0101_ffff);
        write_offset(14'd2, 32'h0101_0080);
        write_offset(14'd3, 32'h0080_0000);
        write_offset(14'd255, 32'hffff_ffff);
        // Offset write beyond the table depth must leave it untouched.
        write_offset(14'h3fff, 32'h1234_5678);
        push_item(OP_UNUSED, 14'h3fff, 32'hffff_ffff, 8'hff, 8'hff, 16'hffff, 8'hff, 8'hff);

        // The same directed sprites in both screen modes.
        for (int m = 0; m < 2; m++)
        begin
            if (m == 1)
                settle_and_config(1'b1);
            decode(8'h00, 8'h00, 16'h0000, 8'h00, 8'd0);
            decode(8'hff, 8'hff, 16'hffff, 8'hff, 8'd0);
            decode(8'hff, 8'hff, 16'hffff, 8'hff, 8'd1);
            decode(8'h00, 8'h00, 16'h0000, 8'h00, 8'd2);
            decode(8'hff, 8'h30, 16'hffff, 8'h00, 8'd3);
            decode(8'h80, 8'h40, 16'h1234, 8'h80, 8'd255);
        end

        // Random phases over both modes and three sender idle profiles.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            settle_and_config(screen_mode[p]);
            sender_idle_pct = idle_pct[p];
            burst_left      = 0;
            repeat (PHASE_ITEMS) random_item();
        end

        // Wait for the last results, then let the monitor flag leftovers.
        start <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        final_check <= 1'b1;
        @(posedge clk);
        final_check <= 1'b0;
        @(posedge clk);

        $display("Run covered %0d sprite decodes and %0d table writes", decode_count,
                 write_count);
        $display("over %0d mode register writes with both screen modes", cfg_count);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/sao_pkg.sv
hw/rtl/sao_tables.sv
hw/rtl/sao_decode.sv
hw/rtl/sprite_attribute_offset_decoder.sv
test/sao_decode_monitor.sv
test/tb.sv
